FILE: src/wcpw_pkg.sv
`default_nettype none
package wcpw_pkg;

  // Default capacity and fixed field widths
  localparam int MAX_ENTRIES_DEF = 64;
  localparam int CNT_W           = 7;
  localparam int SP_W            = 4;
  localparam int CRD_W           = 24;
  localparam int BOX_W           = 22;
  localparam int CUT_W           = 48;
  localparam int EXP_W           = 44;
  localparam int CFG_W           = 48;
  localparam int IDX_OUT_W       = 6;
  localparam int DIV_STEPS       = 26;
  localparam int DIVC_W          = 5;

  // Species codes
  localparam logic [SP_W-1:0] ATOM_CODES  = 4'd11;
  localparam logic [SP_W-1:0] CENTER_CODE = 4'd11;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_BOX_X    = 3'd0,
    CFG_BOX_Y    = 3'd1,
    CFG_BOX_Z    = 3'd2,
    CFG_CUTOFF   = 3'd3,
    CFG_FIRST    = 3'd4,
    CFG_EXPECTED = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OUT_CHK,
    S_OUT_LAT,
    S_IN_CHK,
    S_IN_LAT,
    S_AX_DIFF,
    S_AX_DIV,
    S_AX_MUL,
    S_AX_RES,
    S_AX_SQ,
    S_AX_ACC,
    S_TEST,
    S_OUT_END,
    S_EMIT,
    S_FIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             rd_en;
    logic [CNT_W-1:0] rd_addr;
    logic [CNT_W-1:0] outer;
    logic [CNT_W-1:0] inner;
    logic [1:0]       axis;
    logic             wrap;
    logic             latch_outer;
    logic             clr_acc;
    logic             diff;
    logic             mul;
    logic             res;
    logic             sq;
    logic             acc;
    logic             test;
    logic             out_end;
    logic             emit;
    logic             clear;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] first_idx;
    logic [SP_W-1:0]  rd_species;
    logic             outer_assigned;
    logic             inner_under;
    logic             div_done;
  } status_t;

endpackage
`default_nettype wire

FILE: src/wannier_center_pbc_wrap.sv
// Loading: one item per cycle while busy is low; no result until the last item.
// After the last item: a count pass over atom-center pairs, then a wrap pass over
// pairs of an unassigned entry and an under-coordinated atom, each axis waiting on
// the 26-step image-count divider; then one result per cycle, no stall.
// Reset (rst, synchronous, active high) clears the snapshot and loads default
// configuration; the entry memory holds no reset value.
`default_nettype none
module wannier_center_pbc_wrap #(
  parameter int MAX_ENTRIES = wcpw_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [wcpw_pkg::SP_W-1:0]         species,
  input  wire logic signed [wcpw_pkg::CRD_W-1:0] pos_x,
  input  wire logic signed [wcpw_pkg::CRD_W-1:0] pos_y,
  input  wire logic signed [wcpw_pkg::CRD_W-1:0] pos_z,
  input  wire logic                              last_entry,
  input  wire logic                              cfg_wr_en,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [wcpw_pkg::CFG_W-1:0]        cfg_data,
  output logic                                   result_valid,
  output logic [wcpw_pkg::IDX_OUT_W-1:0]         entry_index,
  output logic signed [wcpw_pkg::CRD_W-1:0]      out_x,
  output logic signed [wcpw_pkg::CRD_W-1:0]      out_y,
  output logic signed [wcpw_pkg::CRD_W-1:0]      out_z,
  output logic                                   under_coordinated,
  output logic                                   was_shifted,
  output logic                                   overflowed,
  output logic                                   last_result
);

  wcpw_pkg::cmd_t    cmd;
  wcpw_pkg::status_t st;

  wcpw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .last_entry (last_entry),
    .st         (st),
    .cmd        (cmd),
    .busy       (busy)
  );

  wcpw_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .st                (st),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .species           (species),
    .pos_x             (pos_x),
    .pos_y             (pos_y),
    .pos_z             (pos_z),
    .result_valid      (result_valid),
    .entry_index       (entry_index),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_z             (out_z),
    .under_coordinated (under_coordinated),
    .was_shifted       (was_shifted),
    .overflowed        (overflowed),
    .last_result       (last_result)
  );

endmodule
`default_nettype wire

FILE: src/wcpw_ctrl.sv
`default_nettype none
module wcpw_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              last_entry,
  input  wire wcpw_pkg::status_t st,
  output wcpw_pkg::cmd_t         cmd,
  output logic                   busy
);

  wcpw_pkg::state_t                state, state_next;
  logic [wcpw_pkg::CNT_W-1:0]      outer, outer_next;
  logic [wcpw_pkg::CNT_W-1:0]      inner, inner_next;
  logic [1:0]                      axis, axis_next;
  logic                            wrap, wrap_next;

  // State and loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wcpw_pkg::S_IDLE;
      outer <= '0;
      inner <= '0;
      axis  <= '0;
      wrap  <= 1'b0;
    end else begin
      state <= state_next;
      outer <= outer_next;
      inner <= inner_next;
      axis  <= axis_next;
      wrap  <= wrap_next;
    end
  end

  assign busy = (state != wcpw_pkg::S_IDLE);

  // Sequence the count pass, the wrap pass and the emit sweep
  always_comb begin
    state_next  = state;
    outer_next  = outer;
    inner_next  = inner;
    axis_next   = axis;
    wrap_next   = wrap;
    cmd         = '0;
    cmd.outer   = outer;
    cmd.inner   = inner;
    cmd.axis    = axis;
    cmd.wrap    = wrap;
    unique case (state)
      wcpw_pkg::S_IDLE: begin
        cmd.load = start;
        if (start && last_entry) begin
          outer_next = '0;
          wrap_next  = 1'b0;
          state_next = wcpw_pkg::S_OUT_CHK;
        end
      end
      wcpw_pkg::S_OUT_CHK: begin
        if (outer >= st.count) begin
          if (!wrap) begin
            outer_next = st.first_idx;
            wrap_next  = 1'b1;
          end else begin
            inner_next = '0;
            state_next = wcpw_pkg::S_EMIT;
          end
        end else if (wrap && st.outer_assigned) begin
          outer_next = outer + 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = outer;
          state_next  = wcpw_pkg::S_OUT_LAT;
        end
      end
      wcpw_pkg::S_OUT_LAT: begin
        cmd.latch_outer = 1'b1;
        if (!wrap && st.rd_species >= wcpw_pkg::ATOM_CODES) begin
          outer_next = outer + 1'b1;
          state_next = wcpw_pkg::S_OUT_CHK;
        end else begin
          inner_next = '0;
          state_next = wcpw_pkg::S_IN_CHK;
        end
      end
      wcpw_pkg::S_IN_CHK: begin
        if (inner >= st.count) begin
          state_next = wcpw_pkg::S_OUT_END;
        end else if (wrap && !st.inner_under) begin
          inner_next = inner + 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = inner;
          state_next  = wcpw_pkg::S_IN_LAT;
        end
      end
      wcpw_pkg::S_IN_LAT: begin
        if (!wrap && st.rd_species != wcpw_pkg::CENTER_CODE) begin
          inner_next = inner + 1'b1;
          state_next = wcpw_pkg::S_IN_CHK;
        end else begin
          cmd.clr_acc = 1'b1;
          axis_next   = '0;
          state_next  = wcpw_pkg::S_AX_DIFF;
        end
      end
      wcpw_pkg::S_AX_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = wrap ? wcpw_pkg::S_AX_DIV : wcpw_pkg::S_AX_RES;
      end
      wcpw_pkg::S_AX_DIV: begin
        if (st.div_done) state_next = wcpw_pkg::S_AX_MUL;
      end
      wcpw_pkg::S_AX_MUL: begin
        cmd.mul    = 1'b1;
        state_next = wcpw_pkg::S_AX_RES;
      end
      wcpw_pkg::S_AX_RES: begin
        cmd.res    = 1'b1;
        state_next = wcpw_pkg::S_AX_SQ;
      end
      wcpw_pkg::S_AX_SQ: begin
        cmd.sq     = 1'b1;
        state_next = wcpw_pkg::S_AX_ACC;
      end
      wcpw_pkg::S_AX_ACC: begin
        cmd.acc = 1'b1;
        if (axis == 2'd2) begin
          state_next = wcpw_pkg::S_TEST;
        end else begin
          axis_next  = axis + 1'b1;
          state_next = wcpw_pkg::S_AX_DIFF;
        end
      end
      wcpw_pkg::S_TEST: begin
        cmd.test   = 1'b1;
        inner_next = inner + 1'b1;
        state_next = wcpw_pkg::S_IN_CHK;
      end
      wcpw_pkg::S_OUT_END: begin
        cmd.out_end = 1'b1;
        outer_next  = outer + 1'b1;
        state_next  = wcpw_pkg::S_OUT_CHK;
      end
      wcpw_pkg::S_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = inner;
        inner_next  = inner + 1'b1;
        if (inner + 1'b1 >= st.count) state_next = wcpw_pkg::S_FIN;
      end
      wcpw_pkg::S_FIN: begin
        cmd.clear  = 1'b1;
        state_next = wcpw_pkg::S_IDLE;
      end
      default: state_next = wcpw_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/wcpw_datapath.sv
`default_nettype none
module wcpw_datapath #(
  parameter int MAX_ENTRIES = wcpw_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire wcpw_pkg::cmd_t                    cmd,
  output wcpw_pkg::status_t                      st,
  input  wire logic                              cfg_wr_en,
  input  wire logic [2:0]                        cfg_index,
  input  wire logic [wcpw_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic [wcpw_pkg::SP_W-1:0]         species,
  input  wire logic signed [wcpw_pkg::CRD_W-1:0] pos_x,
  input  wire logic signed [wcpw_pkg::CRD_W-1:0] pos_y,
  input  wire logic signed [wcpw_pkg::CRD_W-1:0] pos_z,
  output logic                                   result_valid,
  output logic [wcpw_pkg::IDX_OUT_W-1:0]         entry_index,
  output logic signed [wcpw_pkg::CRD_W-1:0]      out_x,
  output logic signed [wcpw_pkg::CRD_W-1:0]      out_y,
  output logic signed [wcpw_pkg::CRD_W-1:0]      out_z,
  output logic                                   under_coordinated,
  output logic                                   was_shifted,
  output logic                                   overflowed,
  output logic                                   last_result
);

  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int MEM_W = wcpw_pkg::SP_W + 3 * wcpw_pkg::CRD_W;
  localparam int CW    = wcpw_pkg::CRD_W;
  localparam int BW    = wcpw_pkg::BOX_W;
  localparam logic [wcpw_pkg::CNT_W-1:0] MAX_CNT = wcpw_pkg::CNT_W'(MAX_ENTRIES);
  localparam logic signed [CW+2:0] SAT_MAX = 27'sd8388607;
  localparam logic signed [CW+2:0] SAT_MIN = -27'sd8388608;

  // Configuration registers
  logic [BW-1:0]                 box_x, box_y, box_z;
  logic [wcpw_pkg::CUT_W-1:0]    cutoff_sq;
  logic [wcpw_pkg::CNT_W-1:0]    first_idx;
  logic [wcpw_pkg::EXP_W-1:0]    expected;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_x     <= '1;
      box_y     <= '1;
      box_z     <= '1;
      cutoff_sq <= '0;
      first_idx <= '0;
      expected  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wcpw_pkg::CFG_BOX_X:    box_x     <= cfg_data[BW-1:0];
        wcpw_pkg::CFG_BOX_Y:    box_y     <= cfg_data[BW-1:0];
        wcpw_pkg::CFG_BOX_Z:    box_z     <= cfg_data[BW-1:0];
        wcpw_pkg::CFG_CUTOFF:   cutoff_sq <= cfg_data[wcpw_pkg::CUT_W-1:0];
        wcpw_pkg::CFG_FIRST:    first_idx <= cfg_data[wcpw_pkg::CNT_W-1:0];
        wcpw_pkg::CFG_EXPECTED: expected  <= cfg_data[wcpw_pkg::EXP_W-1:0];
        default: ;
      endcase
    end
  end

  // Entry memory: species and coordinates, one read and one write port
  logic [MEM_W-1:0] mem [MAX_ENTRIES];
  logic [MEM_W-1:0] rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MEM_W-1:0] mem_wdata;

  logic [wcpw_pkg::CNT_W-1:0] count;
  logic                       ovf;
  logic [wcpw_pkg::SP_W-1:0]  o_sp;
  logic signed [CW-1:0]       o_x, o_y, o_z;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count[AW-1:0];
    mem_wdata = {species, pos_x, pos_y, pos_z};
    if (cmd.load && count < MAX_CNT) begin
      mem_we = 1'b1;
    end else if (cmd.out_end && cmd.wrap) begin
      mem_we    = 1'b1;
      mem_waddr = cmd.outer[AW-1:0];
      mem_wdata = {o_sp, o_x, o_y, o_z};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd.rd_en) rd_q <= mem[cmd.rd_addr[AW-1:0]];
  end

  logic [wcpw_pkg::SP_W-1:0] rd_sp;
  logic signed [CW-1:0]      rd_x, rd_y, rd_z;
  assign rd_sp = rd_q[MEM_W-1 -: wcpw_pkg::SP_W];
  assign rd_x  = rd_q[3*CW-1 -: CW];
  assign rd_y  = rd_q[2*CW-1 -: CW];
  assign rd_z  = rd_q[CW-1:0];

  // Per-entry flags and snapshot counters
  logic [MAX_ENTRIES-1:0] assigned_f, under_f, shifted_f;
  logic [wcpw_pkg::CNT_W-1:0] cnt;

  // Axis selection; an atom that is also the tested entry reads the live copy
  logic signed [CW-1:0] o_sel, i_sel, ix, iy, iz;
  logic [BW-1:0]        box_sel;
  logic                 self_pair;

  assign self_pair = cmd.wrap && (cmd.inner == cmd.outer);
  assign ix = self_pair ? o_x : rd_x;
  assign iy = self_pair ? o_y : rd_y;
  assign iz = self_pair ? o_z : rd_z;

  always_comb begin
    case (cmd.axis)
      2'd0:    begin o_sel = o_x; i_sel = ix; box_sel = box_x; end
      2'd1:    begin o_sel = o_y; i_sel = iy; box_sel = box_y; end
      default: begin o_sel = o_z; i_sel = iz; box_sel = box_z; end
    endcase
  end

  // Difference and magnitude
  logic signed [CW:0] d;
  logic [CW-1:0]      m_abs;
  assign d     = {o_sel[CW-1], o_sel} - {i_sel[CW-1], i_sel};
  assign m_abs = d[CW] ? CW'(-d) : d[CW-1:0];

  // Image count divider: q = (2m + box) / (2box), one quotient bit per cycle
  localparam int DIVN_W = wcpw_pkg::DIV_STEPS;
  logic [DIVN_W-1:0]      div_n;
  logic [BW:0]            div_rem;
  logic [DIVN_W-1:0]      div_q;
  logic [wcpw_pkg::DIVC_W-1:0] div_cnt;
  logic [BW+1:0]          div_t;
  logic [BW:0]            div_d;

  assign div_d = {box_sel, 1'b0};
  assign div_t = {div_rem, div_n[DIVN_W-1]};

  logic [CW-1:0]   m_r;
  logic            neg_r;
  logic [CW:0]     prod_r;
  logic [CW:0]     ae_r;
  logic [2*CW+0:0] sq_r;
  logic [2*CW+2:0] acc_r;
  logic [CW:0]     prod_ax [3];
  logic [2:0]      neg_ax;

  logic signed [CW+1:0] e;
  logic [2*DIVN_W-1:0]  qprod;
  logic [2*CW+1:0]      sqp;
  assign e     = $signed({2'b00, m_r}) - $signed({1'b0, prod_r});
  assign qprod = div_q * {{(DIVN_W-BW){1'b0}}, box_sel};
  assign sqp   = ae_r * ae_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.diff && cmd.wrap) begin
      div_cnt <= wcpw_pkg::DIVC_W'(wcpw_pkg::DIV_STEPS);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      div_n   <= {1'b0, m_abs, 1'b0} + DIVN_W'(box_sel);
      div_rem <= '0;
      div_q   <= '0;
    end else if (div_cnt != '0) begin
      div_n <= {div_n[DIVN_W-2:0], 1'b0};
      if (div_t >= {1'b0, div_d}) begin
        div_rem <= (BW+1)'(div_t - {1'b0, div_d});
        div_q   <= {div_q[DIVN_W-2:0], 1'b1};
      end else begin
        div_rem <= div_t[BW:0];
        div_q   <= {div_q[DIVN_W-2:0], 1'b0};
      end
    end
  end

  // Per-axis arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      m_r    <= m_abs;
      neg_r  <= d[CW];
      prod_r <= '0;
    end
    if (cmd.mul) prod_r <= qprod[CW:0];
    if (cmd.res) ae_r <= e[CW+1] ? (CW+1)'(-e) : e[CW:0];
    if (cmd.sq) sq_r <= sqp[2*CW:0];
    if (cmd.clr_acc) acc_r <= '0;
    else if (cmd.acc) begin
      acc_r               <= acc_r + (2*CW+3)'(sq_r);
      prod_ax[cmd.axis]   <= prod_r;
      neg_ax[cmd.axis]    <= neg_r;
    end
  end

  // Shift by whole boxes and saturate
  function automatic logic signed [CW-1:0] shift_sat(
    input logic signed [CW-1:0] c,
    input logic [CW:0]          p,
    input logic                 n
  );
    logic signed [CW+2:0] s;
    s = n ? ($signed({{3{c[CW-1]}}, c}) + $signed({2'b00, p}))
          : ($signed({{3{c[CW-1]}}, c}) - $signed({2'b00, p}));
    if (s > SAT_MAX) return SAT_MAX[CW-1:0];
    else if (s < SAT_MIN) return SAT_MIN[CW-1:0];
    else return s[CW-1:0];
  endfunction

  logic match;
  logic moved;
  logic [3:0] want;
  assign match = acc_r < {3'b0, cutoff_sq};
  assign moved = (prod_ax[0] != '0) || (prod_ax[1] != '0) || (prod_ax[2] != '0);
  assign want  = expected[{o_sp, 2'b00} +: 4];

  // Outer entry registers and match count
  always_ff @(posedge clk) begin
    if (cmd.latch_outer) begin
      o_sp <= rd_sp;
      o_x  <= rd_x;
      o_y  <= rd_y;
      o_z  <= rd_z;
    end else if (cmd.test && cmd.wrap && match) begin
      o_x <= shift_sat(o_x, prod_ax[0], neg_ax[0]);
      o_y <= shift_sat(o_y, prod_ax[1], neg_ax[1]);
      o_z <= shift_sat(o_z, prod_ax[2], neg_ax[2]);
    end
    if (cmd.latch_outer) cnt <= '0;
    else if (cmd.test && !cmd.wrap && match) cnt <= cnt + 1'b1;
  end

  // Snapshot control state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count      <= '0;
      ovf        <= 1'b0;
      assigned_f <= '0;
      under_f    <= '0;
      shifted_f  <= '0;
    end else begin
      if (cmd.load) begin
        if (count < MAX_CNT) count <= count + 1'b1;
        else ovf <= 1'b1;
      end
      if (cmd.test && match) begin
        if (!cmd.wrap) assigned_f[cmd.inner[AW-1:0]] <= 1'b1;
        else if (moved) shifted_f[cmd.outer[AW-1:0]] <= 1'b1;
      end
      if (cmd.out_end && !cmd.wrap && (cnt < {3'b000, want}))
        under_f[cmd.outer[AW-1:0]] <= 1'b1;
    end
  end

  // Result strobe and flags, captured with the memory read
  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= cmd.emit;
    if (cmd.emit) begin
      entry_index       <= wcpw_pkg::IDX_OUT_W'(cmd.rd_addr);
      under_coordinated <= under_f[cmd.rd_addr[AW-1:0]];
      was_shifted       <= shifted_f[cmd.rd_addr[AW-1:0]];
      overflowed        <= ovf;
      last_result       <= (cmd.rd_addr + 1'b1 == count);
    end
  end

  assign out_x = rd_x;
  assign out_y = rd_y;
  assign out_z = rd_z;

  assign st.count          = count;
  assign st.first_idx      = first_idx;
  assign st.rd_species     = rd_sp;
  assign st.outer_assigned = assigned_f[cmd.outer[AW-1:0]];
  assign st.inner_under    = under_f[cmd.inner[AW-1:0]];
  assign st.div_done       = (div_cnt == '0);

endmodule
`default_nettype wire

FILE: src/wcpw_checker.sv
`default_nettype none
module wcpw_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       result_valid,
  input wire logic [5:0] entry_index,
  input wire logic       last_result
);

  // Results only come out while the block is working on a snapshot
  a_result_in_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy) else $error("result outside busy");

  // Results of a snapshot come back to back until the last one
  a_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |=> result_valid) else $error("gap in results");

  // Nothing follows the last result
  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_result |=> !result_valid) else $error("result after last");

  // Indexes advance by one within a burst
  a_index: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_result |=> entry_index == 6'($past(entry_index) + 1'b1))
    else $error("index out of order");

  // An accepted item never meets a result in the next cycle
  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !result_valid) else $error("result after load");

endmodule

bind wannier_center_pbc_wrap wcpw_checker u_wcpw_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .entry_index  (entry_index),
  .last_result  (last_result)
);
`default_nettype wire
